/* src/ckrb_pkg.sv */
// Shared constants, codes and the result record for the colour-key rectangle blitter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ckrb_pkg;

	localparam int SCREEN_WIDTH = 320;
	localparam int SCREEN_BYTES = 64000;

	// Field widths of the request and result channels
	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int WIDTH_W = 9;
	localparam int HEIGHT_W = 8;
	localparam int PITCH_W = 11;
	localparam int PIXEL_W = 8;
	localparam int ADDR_W  = 16;
	localparam int SRC_W   = 18;

	// Linear destination address before truncation: wide enough for the furthest
	// corner plus every row step and column, so the off-screen test is exact.
	localparam int LIN_W = 18;

	typedef enum logic {
		OP_START = 1'b0,
		OP_PIXEL = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  write_addr;
		logic [SRC_W-1:0]   read_offset;
		logic               layer_out;
		logic [PIXEL_W-1:0] pixel_out;
		logic               write_enable;
		logic               off_screen;
		logic               last_pixel;
	} result_t;

endpackage

/* src/ckrb_req_if.sv */
// Request channel of the blitter: valid/ready handshake with start and pixel fields.
// Depends on ckrb_pkg for the field widths.
interface ckrb_req_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [ckrb_pkg::X_W-1:0]        dest_x;
	logic [ckrb_pkg::Y_W-1:0]        dest_y;
	logic [ckrb_pkg::WIDTH_W-1:0]    rect_width;
	logic [ckrb_pkg::HEIGHT_W-1:0]   rect_height;
	logic [ckrb_pkg::PITCH_W-1:0]    source_pitch;
	logic                            key_mode;
	logic                            target_layer;
	logic [ckrb_pkg::PIXEL_W-1:0]    pixel_in;

	modport source (
		output valid, opcode, dest_x, dest_y, rect_width, rect_height, source_pitch,
		       key_mode, target_layer, pixel_in,
		input  ready
	);
	modport sink (
		input  valid, opcode, dest_x, dest_y, rect_width, rect_height, source_pitch,
		       key_mode, target_layer, pixel_in,
		output ready
	);
endinterface

/* src/ckrb_res_if.sv */
// Result channel of the blitter: valid/ready handshake with one pixel write per pixel request of a running blit.
// Depends on ckrb_pkg for the field widths.
interface ckrb_res_if;
	logic                          valid;
	logic                          ready;
	logic [ckrb_pkg::ADDR_W-1:0]   write_addr;
	logic [ckrb_pkg::SRC_W-1:0]    read_offset;
	logic                          layer_out;
	logic [ckrb_pkg::PIXEL_W-1:0]  pixel_out;
	logic                          write_enable;
	logic                          off_screen;
	logic                          last_pixel;

	modport source (
		output valid, write_addr, read_offset, layer_out, pixel_out, write_enable,
		       off_screen, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, write_addr, read_offset, layer_out, pixel_out, write_enable,
		       off_screen, last_pixel,
		output ready
	);
endinterface

/* src/ckrb_ctrl.sv */
// Blit control: latches the rectangle on a start request, walks column and row counters
// and forms the result of each pixel request. Depends on ckrb_pkg and ckrb_req_if.
module ckrb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	ckrb_req_if.sink             req,
	input  logic                 space,
	output logic                 res_valid,
	output ckrb_pkg::result_t    res_data
);

	logic                              active_q;
	logic [ckrb_pkg::WIDTH_W-1:0]      col_q;
	logic [ckrb_pkg::HEIGHT_W-1:0]     row_q;
	logic [ckrb_pkg::LIN_W-1:0]        dest_base_q;
	logic [ckrb_pkg::SRC_W-1:0]        src_base_q;
	logic [ckrb_pkg::WIDTH_W-1:0]      width_q;
	logic [ckrb_pkg::HEIGHT_W-1:0]     height_q;
	logic [ckrb_pkg::PITCH_W-1:0]      pitch_q;
	logic                              key_mode_q;
	logic                              layer_q;

	logic                              accept;
	logic                              is_start;
	logic                              pixel_go;
	logic [ckrb_pkg::LIN_W-1:0]        lin_addr;
	logic [ckrb_pkg::SRC_W-1:0]        src_addr;
	logic                              off;
	logic                              skip;
	logic                              last_col;
	logic                              last;
	logic [ckrb_pkg::LIN_W-1:0]        start_base;

	assign req.ready = space;
	assign accept    = req.valid && space;
	assign is_start  = (ckrb_pkg::opcode_t'(req.opcode) == ckrb_pkg::OP_START);
	assign pixel_go  = accept && !is_start && active_q;

	assign lin_addr = dest_base_q + ckrb_pkg::LIN_W'(col_q);
	assign src_addr = src_base_q + ckrb_pkg::SRC_W'(col_q);
	assign off      = (lin_addr >= ckrb_pkg::LIN_W'(ckrb_pkg::SCREEN_BYTES));
	assign skip     = key_mode_q && (req.pixel_in == '0);
	assign last_col = ({1'b0, col_q} + (ckrb_pkg::WIDTH_W+1)'(1)) >= {1'b0, width_q};
	assign last     = last_col
		&& (({1'b0, row_q} + (ckrb_pkg::HEIGHT_W+1)'(1)) >= {1'b0, height_q});

	// Constant multiply by the screen width reduces to shifts and adds
	assign start_base = ckrb_pkg::LIN_W'(req.dest_y) * ckrb_pkg::LIN_W'(ckrb_pkg::SCREEN_WIDTH)
		+ ckrb_pkg::LIN_W'(req.dest_x);

	always_comb begin
		res_valid             = pixel_go;
		res_data.write_addr   = lin_addr[ckrb_pkg::ADDR_W-1:0];
		res_data.read_offset  = src_addr;
		res_data.layer_out    = layer_q;
		res_data.pixel_out    = req.pixel_in;
		res_data.write_enable = !off && !skip;
		res_data.off_screen   = off;
		res_data.last_pixel   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			dest_base_q <= '0;
			src_base_q  <= '0;
			width_q     <= '0;
			height_q    <= '0;
			pitch_q     <= '0;
			key_mode_q  <= 1'b0;
			layer_q     <= 1'b0;
		end else if (accept && is_start) begin
			width_q     <= req.rect_width;
			height_q    <= req.rect_height;
			pitch_q     <= req.source_pitch;
			key_mode_q  <= req.key_mode;
			layer_q     <= req.target_layer;
			dest_base_q <= start_base;
			src_base_q  <= '0;
			col_q       <= '0;
			row_q       <= '0;
			active_q    <= (req.rect_width != '0) && (req.rect_height != '0);
		end else if (pixel_go) begin
			if (last) begin
				active_q <= 1'b0;
				col_q    <= '0;
				row_q    <= '0;
			end else if (last_col) begin
				col_q       <= '0;
				row_q       <= row_q + ckrb_pkg::HEIGHT_W'(1);
				dest_base_q <= dest_base_q + ckrb_pkg::LIN_W'(ckrb_pkg::SCREEN_WIDTH);
				src_base_q  <= src_base_q + ckrb_pkg::SRC_W'(pitch_q);
			end else begin
				col_q <= col_q + ckrb_pkg::WIDTH_W'(1);
			end
		end
	end

endmodule

/* src/ckrb_out_reg.sv */
// Result register: holds one finished pixel write until the sink takes it.
// Depends on ckrb_pkg and ckrb_res_if.
module ckrb_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ckrb_pkg::result_t    in_data,
	output logic                 space,
	ckrb_res_if.source           res
);

	logic                 valid_q;
	ckrb_pkg::result_t    data_q;

	// Load whenever the register is empty or being drained this cycle
	assign space = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (space && in_valid) begin
			data_q <= in_data;
		end
	end

	assign res.valid        = valid_q;
	assign res.write_addr   = data_q.write_addr;
	assign res.read_offset  = data_q.read_offset;
	assign res.layer_out    = data_q.layer_out;
	assign res.pixel_out    = data_q.pixel_out;
	assign res.write_enable = data_q.write_enable;
	assign res.off_screen   = data_q.off_screen;
	assign res.last_pixel   = data_q.last_pixel;

endmodule

/* src/color_key_rect_blitter.sv */
// Top level of the colour-key rectangle blitter for a 320-pixel, 8-bit frame buffer.
// Depends on ckrb_pkg, ckrb_req_if, ckrb_res_if, ckrb_ctrl and ckrb_out_reg.
//
//   channel  direction  handshake      carries
//   req      in         valid/ready    start (corner, size, pitch, mode, layer) or pixel
//   res      out        valid/ready    write address, source offset, pixel, flags
//
// One request is taken every cycle while the result register is empty or draining.
// A pixel request's result appears on res in the cycle after acceptance; a start request,
// or a pixel request arriving with no blit running, gives no result.
// Reset clears the blit state and empties the result register; the block is idle after.
// A stall on res holds the result register, and req.ready falls in the same cycle.
module color_key_rect_blitter (
	input  logic        clk,
	input  logic        arst_n,
	ckrb_req_if.sink    req,
	ckrb_res_if.source  res
);

	logic                 space;     // result register can take a new entry
	logic                 res_valid; // accepted pixel request that yields a write
	ckrb_pkg::result_t    res_data;

	// Counters, latched rectangle and per-pixel address arithmetic
	ckrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.space     (space),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// Hold each result until the sink takes it
	ckrb_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res_data),
		.space    (space),
		.res      (res)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the colour-key rectangle blitter: random and directed requests.
// Depends on ckrb_pkg, ckrb_req_if, ckrb_res_if and color_key_rect_blitter.
module testbench;

	// One request as the bench sees it, start and pixel fields together
	typedef struct {
		ckrb_pkg::opcode_t                  op;
		logic [ckrb_pkg::X_W-1:0]           dest_x;
		logic [ckrb_pkg::Y_W-1:0]           dest_y;
		logic [ckrb_pkg::WIDTH_W-1:0]       rect_width;
		logic [ckrb_pkg::HEIGHT_W-1:0]      rect_height;
		logic [ckrb_pkg::PITCH_W-1:0]       source_pitch;
		logic                               key_mode;
		logic                               target_layer;
		logic [ckrb_pkg::PIXEL_W-1:0]       pixel_in;
	} blit_req_t;

	// Tracks the blit in progress and queues the pixel writes it must produce
	class blit_scoreboard;
		bit                             busy;
		logic [ckrb_pkg::WIDTH_W-1:0]   col;
		logic [ckrb_pkg::HEIGHT_W-1:0]  row;
		logic [ckrb_pkg::LIN_W-1:0]     row_lin_base;
		logic [ckrb_pkg::SRC_W-1:0]     row_src_base;
		logic [ckrb_pkg::WIDTH_W-1:0]   width;
		logic [ckrb_pkg::HEIGHT_W-1:0]  height;
		logic [ckrb_pkg::PITCH_W-1:0]   pitch;
		logic                           key;
		logic                           layer;
		ckrb_pkg::result_t              pending_writes[$];
		int unsigned                    errors;

		// Note one accepted request; returns 0 when the block ignores it
		function bit note_request(blit_req_t rq);
			ckrb_pkg::result_t           w;
			logic [ckrb_pkg::LIN_W-1:0]  lin;
			bit                          last_col;
			if (rq.op == ckrb_pkg::OP_START) begin
				width        = rq.rect_width;
				height       = rq.rect_height;
				pitch        = rq.source_pitch;
				key          = rq.key_mode;
				layer        = rq.target_layer;
				row_lin_base = ckrb_pkg::LIN_W'(rq.dest_y)
					* ckrb_pkg::LIN_W'(ckrb_pkg::SCREEN_WIDTH)
					+ ckrb_pkg::LIN_W'(rq.dest_x);
				row_src_base = '0;
				col          = '0;
				row          = '0;
				busy         = (width != 0) && (height != 0);
				return 1'b1;
			end
			if (!busy)
				return 1'b0;
			lin            = row_lin_base + ckrb_pkg::LIN_W'(col);
			w.write_addr   = lin[ckrb_pkg::ADDR_W-1:0];
			w.read_offset  = row_src_base + ckrb_pkg::SRC_W'(col);
			w.layer_out    = layer;
			w.pixel_out    = rq.pixel_in;
			w.off_screen   = (lin >= ckrb_pkg::LIN_W'(ckrb_pkg::SCREEN_BYTES));
			w.write_enable = !w.off_screen && !(key && rq.pixel_in == '0);
			last_col       = (int'(col) + 1 >= int'(width));
			w.last_pixel   = last_col && (int'(row) + 1 >= int'(height));
			pending_writes.push_back(w);
			if (w.last_pixel) begin
				busy = 1'b0;
				col  = '0;
				row  = '0;
			end else if (last_col) begin
				col          = '0;
				row          = row + 1'b1;
				row_lin_base = row_lin_base + ckrb_pkg::LIN_W'(ckrb_pkg::SCREEN_WIDTH);
				row_src_base = row_src_base + ckrb_pkg::SRC_W'(pitch);
			end else begin
				col = col + 1'b1;
			end
			return 1'b1;
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted write against the oldest one queued
		function void check_write(ckrb_pkg::result_t got);
			ckrb_pkg::result_t want;
			if (pending_writes.size() == 0) begin
				$error("write_addr: expected nothing, got %0h", got.write_addr);
				errors++;
				return;
			end
			want = pending_writes.pop_front();
			compare("write_addr",   want.write_addr,   got.write_addr);
			compare("read_offset",  want.read_offset,  got.read_offset);
			compare("layer_out",    want.layer_out,    got.layer_out);
			compare("pixel_out",    want.pixel_out,    got.pixel_out);
			compare("write_enable", want.write_enable, got.write_enable);
			compare("off_screen",   want.off_screen,   got.off_screen);
			compare("last_pixel",   want.last_pixel,   got.last_pixel);
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Requests that count towards the stimulus total (ignored pixels do not)
	int unsigned taken_items = 0;
	// Set while both sides run without idling
	bit calm = 1'b0;

	blit_scoreboard board = new;

	ckrb_req_if req_ch ();
	ckrb_res_if res_ch ();

	color_key_rect_blitter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// Safety net: end the run if the block hangs
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic blit_req_t start_req(logic [ckrb_pkg::X_W-1:0] x,
			logic [ckrb_pkg::Y_W-1:0] y, logic [ckrb_pkg::WIDTH_W-1:0] w,
			logic [ckrb_pkg::HEIGHT_W-1:0] h, logic [ckrb_pkg::PITCH_W-1:0] p,
			logic k, logic l);
		blit_req_t rq;
		rq.op           = ckrb_pkg::OP_START;
		rq.dest_x       = x;
		rq.dest_y       = y;
		rq.rect_width   = w;
		rq.rect_height  = h;
		rq.source_pitch = p;
		rq.key_mode     = k;
		rq.target_layer = l;
		rq.pixel_in     = ckrb_pkg::PIXEL_W'($urandom);
		return rq;
	endfunction

	function automatic blit_req_t pixel_req(logic [ckrb_pkg::PIXEL_W-1:0] p);
		blit_req_t rq;
		// Start fields are don't-care on a pixel request: fill them with noise
		rq.op           = ckrb_pkg::OP_PIXEL;
		rq.dest_x       = ckrb_pkg::X_W'($urandom);
		rq.dest_y       = ckrb_pkg::Y_W'($urandom);
		rq.rect_width   = ckrb_pkg::WIDTH_W'($urandom);
		rq.rect_height  = ckrb_pkg::HEIGHT_W'($urandom);
		rq.source_pitch = ckrb_pkg::PITCH_W'($urandom);
		rq.key_mode     = 1'($urandom);
		rq.target_layer = 1'($urandom);
		rq.pixel_in     = p;
		return rq;
	endfunction

	// Offer one request, with a random hold-off, and wait for the handshake.
	// Valid is written once per edge: lowered only during a gap, raised for the offer.
	task automatic issue(blit_req_t rq);
		while (!calm && $urandom_range(0, 99) < 38) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= rq.op;
		req_ch.dest_x       <= rq.dest_x;
		req_ch.dest_y       <= rq.dest_y;
		req_ch.rect_width   <= rq.rect_width;
		req_ch.rect_height  <= rq.rect_height;
		req_ch.source_pitch <= rq.source_pitch;
		req_ch.key_mode     <= rq.key_mode;
		req_ch.target_layer <= rq.target_layer;
		req_ch.pixel_in     <= rq.pixel_in;
		// Ready is sampled with its pre-edge value, the one the block acted on
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (board.note_request(rq))
			taken_items++;
	endtask

	// Result side: stall at random, except in the calm stretch
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 38);
		end
	end

	// Check every accepted write
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_write(ckrb_pkg::result_t'{res_ch.write_addr, res_ch.read_offset,
				res_ch.layer_out, res_ch.pixel_out, res_ch.write_enable,
				res_ch.off_screen, res_ch.last_pixel});
	end

	initial begin
		int unsigned sel;
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		int unsigned n;

		// Hold every request input at a known value through reset
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= ckrb_pkg::OP_START;
		req_ch.dest_x       <= '0;
		req_ch.dest_y       <= '0;
		req_ch.rect_width   <= '0;
		req_ch.rect_height  <= '0;
		req_ch.source_pitch <= '0;
		req_ch.key_mode     <= 1'b0;
		req_ch.target_layer <= 1'b0;
		req_ch.pixel_in     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pixel with no blit running: drop it
		issue(pixel_req(8'hFF));
		// Empty rectangles leave the block idle; the following pixel is dropped
		issue(start_req(9'd20, 8'd20, 9'd0, 8'd5, 11'd7, 1'b1, 1'b0));
		issue(pixel_req(8'h11));
		issue(start_req(9'd20, 8'd20, 9'd5, 8'd0, 11'd7, 1'b0, 1'b1));
		issue(pixel_req(8'h22));
		// Bottom-right corner: the second column wraps past the right edge and
		// the rest lands off screen; zero pitch repeats the source offsets;
		// keyed mode skips the zero pixel
		issue(start_req(9'd319, 8'd199, 9'd2, 8'd2, 11'd0, 1'b1, 1'b1));
		issue(pixel_req(8'h00));
		issue(pixel_req(8'hFF));
		issue(pixel_req(8'h00));
		issue(pixel_req(8'hAA));
		// Widest pitch, then a start in mid-blit that abandons it
		issue(start_req(9'd0, 8'd0, 9'd3, 8'd2, 11'd2047, 1'b0, 1'b0));
		issue(pixel_req(8'h00));
		issue(pixel_req(8'h01));
		issue(pixel_req(8'h02));
		issue(pixel_req(8'h7F));
		// Field maxima for the corner: off screen from the first pixel
		issue(start_req(9'd511, 8'd255, 9'd1, 8'd1, 11'd1024, 1'b1, 1'b0));
		issue(pixel_req(8'h80));
		// Pixel after the last one: drop it
		issue(pixel_req(8'h33));
		// Opaque copy keeps a zero pixel, over three rows
		issue(start_req(9'd100, 8'd50, 9'd2, 8'd3, 11'd1, 1'b0, 1'b1));
		issue(pixel_req(8'h00));
		issue(pixel_req(8'h40));
		issue(pixel_req(8'h08));
		issue(pixel_req(8'h10));
		issue(pixel_req(8'h20));
		issue(pixel_req(8'hFE));

		// Random blits: mostly complete small rectangles, a few wide rows and tall
		// columns (the tall ones reach the source offset wrap), plus empty starts,
		// cut-short blits and stray trailing pixels
		while (taken_items < 1400) begin
			calm = (taken_items >= 500 && taken_items < 800);
			sel  = $urandom_range(0, 99);
			if (sel < 84) begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
			end else if (sel < 88) begin
				w = $urandom_range(200, 511);
				h = 1;
			end else if (sel < 92) begin
				w = $urandom_range(1, 2);
				h = $urandom_range(128, 255);
			end else begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 511);
				h = (w == 0) ? $urandom_range(0, 255) : 0;
			end
			x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 319);
			y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 199);
			issue(start_req(ckrb_pkg::X_W'(x), ckrb_pkg::Y_W'(y), ckrb_pkg::WIDTH_W'(w),
				ckrb_pkg::HEIGHT_W'(h), ckrb_pkg::PITCH_W'($urandom_range(0, 2047)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			n = w * h;
			if (n == 0)
				n = $urandom_range(1, 3);
			else if ($urandom_range(0, 99) < 8)
				n = $urandom_range(0, n - 1);
			else if ($urandom_range(0, 99) < 5)
				n += $urandom_range(1, 3);
			repeat (n)
				issue(pixel_req(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom)));
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// Drain: wait for every queued write, then keep clocking for stragglers
		while (board.pending_writes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
